>>> rtl/pci_pkg.sv
// shared types, widths and helpers for the pair collision impulse block
package pci_pkg;

  // quotient bits of the impulse division, one per divider stage
  localparam int QW        = 18;
  // numerator and divisor widths of the impulse division
  localparam int NW        = 71;
  localparam int DW        = 53;
  localparam int DIV_STEPS = QW;
  // register stages ahead of the divider
  localparam int FRONT     = 6;
  localparam int NST       = FRONT + DIV_STEPS;
  // lanes: a x, a y, b x, b y
  localparam int LANES     = 4;

  typedef logic [LANES-1:0][NW-1:0] num4_t;
  typedef logic [LANES-1:0][QW-1:0] quo4_t;

  // per-pair data that rides alongside the divider
  typedef struct packed {
    logic [31:0] va;
    logic [31:0] vb;
    logic        sx;
    logic        sy;
    logic        ov;
    logic        app;
  } side_t;

  // saturate a 20-bit signed sum to a signed 16-bit component
  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    logic [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7fff;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/pci_divider.sv
// pipelined restoring divider, four lanes sharing one divisor
module pci_divider (
  input  logic                    clk_i,
  input  logic [pci_pkg::DIV_STEPS-1:0] en_i,
  input  logic [pci_pkg::DW-1:0]  den_i,
  input  pci_pkg::num4_t          num_i,
  input  pci_pkg::side_t          side_i,
  output pci_pkg::quo4_t          quo_o,
  output pci_pkg::side_t          side_o
);
  import pci_pkg::*;

  logic [DW-1:0]             den_q  [DIV_STEPS];
  logic [LANES-1:0][DW-1:0]  rem_q  [DIV_STEPS];
  logic [LANES-1:0][QW-1:0]  lq_q   [DIV_STEPS];
  side_t                     side_q [DIV_STEPS];

  logic [DW-1:0]             den_s  [DIV_STEPS];
  logic [LANES-1:0][DW-1:0]  rem_s  [DIV_STEPS];
  logic [LANES-1:0][QW-1:0]  lq_s   [DIV_STEPS];
  side_t                     side_s [DIV_STEPS];
  logic [LANES-1:0][DW-1:0]  rem_d  [DIV_STEPS];
  logic [LANES-1:0][QW-1:0]  lq_d   [DIV_STEPS];

  // stage sources
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        den_s[s]  = den_i;
        side_s[s] = side_i;
        for (int l = 0; l < LANES; l++) begin
          rem_s[s][l] = num_i[l][NW-1:QW];
          lq_s[s][l]  = num_i[l][QW-1:0];
        end
      end else begin
        den_s[s]  = den_q[s-1];
        side_s[s] = side_q[s-1];
        rem_s[s]  = rem_q[s-1];
        lq_s[s]   = lq_q[s-1];
      end
    end
  end

  // one quotient bit per stage and lane
  always_comb begin
    logic [DW:0] remw;
    logic [DW:0] diff;
    logic        ge;
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        remw = {rem_s[s][l], lq_s[s][l][QW-1]};
        diff = remw - {1'b0, den_s[s]};
        ge   = (remw >= {1'b0, den_s[s]});
        rem_d[s][l] = ge ? diff[DW-1:0] : remw[DW-1:0];
        lq_d[s][l]  = {lq_s[s][l][QW-2:0], ge};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (en_i[s]) begin
        den_q[s]  <= den_s[s];
        side_q[s] <= side_s[s];
        rem_q[s]  <= rem_d[s];
        lq_q[s]   <= lq_d[s];
      end
    end
  end

  assign quo_o  = lq_q[DIV_STEPS-1];
  assign side_o = side_q[DIV_STEPS-1];

endmodule

>>> rtl/pair_collision_impulse.sv
// Impulse response for one circle-circle or circle-box pair per clock.
// A pair word is taken every cycle the output side keeps up; each result
// passes through the front stages, the divider and the output register. Six
// stages form the contact normal, the overlap test, the approach dot
// product and the impulse numerator; an 18-stage restoring divider then
// resolves one quotient bit per stage in all four velocity lanes at once,
// and a final output register adds, saturates and holds the word. Stalls
// squeeze out empty stages, so a word is accepted while results wait if any stage is empty.
module pair_collision_impulse (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        cmd_i,
  input  logic [31:0] a_pos_i,
  input  logic [31:0] a_vel_i,
  input  logic [15:0] a_inv_mass_i,
  input  logic [11:0] a_diameter_i,
  input  logic [31:0] b_pos_i,
  input  logic [31:0] b_vel_i,
  input  logic [15:0] b_inv_mass_i,
  input  logic [15:0] b_width_i,
  input  logic [15:0] b_height_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] a_vel_new_o,
  output logic [31:0] b_vel_new_o,
  output logic        overlap_o,
  output logic        impulse_applied_o
);
  import pci_pkg::*;

  // pipeline control
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;
  logic           out_v_q;
  logic           rdy_out;

  assign rdy_out = !out_v_q || !stall_i;

  always_comb begin
    rdy[NST] = rdy_out;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (rdy_out) begin
        out_v_q <= v_q[NST-1];
      end
    end
  end

  // stage 0: contact normal and relative velocity
  logic signed [17:0] pax, pay, pbx, pby, bx_hi, by_hi, qx, qy, nx0_d, ny0_d;
  logic signed [16:0] rvx0_d, rvy0_d;
  logic [16:0]        s0_d;

  always_comb begin
    pax   = {{2{a_pos_i[15]}}, a_pos_i[15:0]};
    pay   = {{2{a_pos_i[31]}}, a_pos_i[31:16]};
    pbx   = {{2{b_pos_i[15]}}, b_pos_i[15:0]};
    pby   = {{2{b_pos_i[31]}}, b_pos_i[31:16]};
    bx_hi = pbx + $signed({2'b00, b_width_i});
    by_hi = pby + $signed({2'b00, b_height_i});
    qx    = (pax < pbx) ? pbx : pax;
    qx    = (qx > bx_hi) ? bx_hi : qx;
    qy    = (pay < pby) ? pby : pay;
    qy    = (qy > by_hi) ? by_hi : qy;
    if (cmd_i) begin
      nx0_d = pax - qx;
      ny0_d = pay - qy;
      s0_d  = {5'b0, a_diameter_i};
    end else begin
      nx0_d = pax - pbx;
      ny0_d = pay - pby;
      s0_d  = {5'b0, a_diameter_i} + {1'b0, b_width_i};
    end
    rvx0_d = $signed({a_vel_i[15], a_vel_i[15:0]}) - $signed({b_vel_i[15], b_vel_i[15:0]});
    rvy0_d = $signed({a_vel_i[31], a_vel_i[31:16]})
           - $signed({b_vel_i[31], b_vel_i[31:16]});
  end

  logic signed [17:0] nx0_q, ny0_q;
  logic signed [16:0] rvx0_q, rvy0_q;
  logic [16:0]        s0_q;
  logic [31:0]        va0_q, vb0_q;
  logic [15:0]        ia0_q, ib0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      nx0_q  <= nx0_d;
      ny0_q  <= ny0_d;
      rvx0_q <= rvx0_d;
      rvy0_q <= rvy0_d;
      s0_q   <= s0_d;
      va0_q  <= a_vel_i;
      vb0_q  <= b_vel_i;
      ia0_q  <= a_inv_mass_i;
      ib0_q  <= b_inv_mass_i;
    end
  end

  // stage 1: squares and dot product terms
  logic signed [35:0] nxx_w, nyy_w;
  logic signed [34:0] dx1_d, dy1_d;
  logic [33:0]        lim1_d;

  always_comb begin
    nxx_w  = 36'(nx0_q) * 36'(nx0_q);
    nyy_w  = 36'(ny0_q) * 36'(ny0_q);
    dx1_d  = 35'(nx0_q) * 35'(rvx0_q);
    dy1_d  = 35'(ny0_q) * 35'(rvy0_q);
    lim1_d = 34'(s0_q) * 34'(s0_q);
  end

  logic [33:0]        nxx1_q, nyy1_q, lim1_q;
  logic signed [34:0] dx1_q, dy1_q;
  logic signed [17:0] nx1_q, ny1_q;
  logic [31:0]        va1_q, vb1_q;
  logic [15:0]        ia1_q, ib1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      nxx1_q <= nxx_w[33:0];
      nyy1_q <= nyy_w[33:0];
      lim1_q <= lim1_d;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      nx1_q  <= nx0_q;
      ny1_q  <= ny0_q;
      va1_q  <= va0_q;
      vb1_q  <= vb0_q;
      ia1_q  <= ia0_q;
      ib1_q  <= ib0_q;
    end
  end

  // stage 2: squared distance, dot product, overlap test
  logic [35:0]        nn2_d;
  logic signed [35:0] dot2_d;
  logic               ov2_d;

  always_comb begin
    nn2_d  = {2'b00, nxx1_q} + {2'b00, nyy1_q};
    dot2_d = {dx1_q[34], dx1_q} + {dy1_q[34], dy1_q};
    ov2_d  = ({nn2_d, 2'b00} <= {4'b0000, lim1_q});
  end

  logic [35:0]        nn2_q;
  logic signed [35:0] dot2_q;
  logic               ov2_q;
  logic [16:0]        isum2_q;
  logic signed [17:0] nx2_q, ny2_q;
  logic [31:0]        va2_q, vb2_q;
  logic [15:0]        ia2_q, ib2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      nn2_q   <= nn2_d;
      dot2_q  <= dot2_d;
      ov2_q   <= ov2_d;
      isum2_q <= {1'b0, ia1_q} + {1'b0, ib1_q};
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      va2_q   <= va1_q;
      vb2_q   <= vb1_q;
      ia2_q   <= ia1_q;
      ib2_q   <= ib1_q;
    end
  end

  // stage 3: impulse condition, divisor, mass-scaled normal magnitudes
  logic [36:0] ndot3;
  logic [16:0] magx3, magy3;
  logic [17:0] magx_w, magy_w;

  always_comb begin
    ndot3  = 37'd0 - {dot2_q[35], dot2_q};
    magx_w = nx2_q[17] ? 18'(-nx2_q) : nx2_q;
    magy_w = ny2_q[17] ? 18'(-ny2_q) : ny2_q;
    magx3  = magx_w[16:0];
    magy3  = magy_w[16:0];
  end

  logic [36:0]             tdot3_q;
  logic [DW-1:0]           den3_q;
  logic [LANES-1:0][32:0]  p3_q;
  side_t                   side3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      tdot3_q     <= {ndot3[35:0], 1'b0};
      den3_q      <= DW'(nn2_q) * DW'(isum2_q);
      p3_q[0]     <= 33'(magx3) * 33'(ia2_q);
      p3_q[1]     <= 33'(magy3) * 33'(ia2_q);
      p3_q[2]     <= 33'(magx3) * 33'(ib2_q);
      p3_q[3]     <= 33'(magy3) * 33'(ib2_q);
      side3_q.va  <= va2_q;
      side3_q.vb  <= vb2_q;
      side3_q.sx  <= nx2_q[17];
      side3_q.sy  <= ny2_q[17];
      side3_q.ov  <= ov2_q;
      side3_q.app <= ov2_q && dot2_q[35] && (isum2_q != 17'd0);
    end
  end

  // stage 4: numerator partial products, split on the dot product
  logic [LANES-1:0][51:0] pl4_q;
  logic [LANES-1:0][50:0] ph4_q;
  logic [DW-1:0]          den4_q;
  side_t                  side4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int l = 0; l < LANES; l++) begin
        pl4_q[l] <= 52'(p3_q[l]) * 52'(tdot3_q[18:0]);
        ph4_q[l] <= 51'(p3_q[l]) * 51'(tdot3_q[36:19]);
      end
      den4_q  <= den3_q;
      side4_q <= side3_q;
    end
  end

  // stage 5: full numerators with rounding half added
  num4_t         num5_q;
  logic [DW-1:0] den5_q;
  side_t         side5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int l = 0; l < LANES; l++) begin
        num5_q[l] <= NW'(pl4_q[l]) + NW'({ph4_q[l], 19'd0})
                   + NW'(den4_q >> 1);
      end
      den5_q  <= den4_q;
      side5_q <= side4_q;
    end
  end

  // divider stages
  quo4_t quo;
  side_t side_dv;

  pci_divider u_div (
    .clk_i  (clk_i),
    .en_i   (rdy[FRONT +: DIV_STEPS]),
    .den_i  (den5_q),
    .num_i  (num5_q),
    .side_i (side5_q),
    .quo_o  (quo),
    .side_o (side_dv)
  );

  // signed velocity changes, update and saturation
  logic signed [19:0] dl [LANES];
  logic [15:0]        ax_d, ay_d, bx_d, by_d;

  always_comb begin
    dl[0] = side_dv.sx ? -$signed({2'b00, quo[0]}) : $signed({2'b00, quo[0]});
    dl[1] = side_dv.sy ? -$signed({2'b00, quo[1]}) : $signed({2'b00, quo[1]});
    dl[2] = side_dv.sx ? -$signed({2'b00, quo[2]}) : $signed({2'b00, quo[2]});
    dl[3] = side_dv.sy ? -$signed({2'b00, quo[3]}) : $signed({2'b00, quo[3]});
    if (side_dv.app) begin
      ax_d = sat16($signed({{4{side_dv.va[15]}}, side_dv.va[15:0]}) + dl[0]);
      ay_d = sat16($signed({{4{side_dv.va[31]}}, side_dv.va[31:16]}) + dl[1]);
      bx_d = sat16($signed({{4{side_dv.vb[15]}}, side_dv.vb[15:0]}) - dl[2]);
      by_d = sat16($signed({{4{side_dv.vb[31]}}, side_dv.vb[31:16]}) - dl[3]);
    end else begin
      ax_d = side_dv.va[15:0];
      ay_d = side_dv.va[31:16];
      bx_d = side_dv.vb[15:0];
      by_d = side_dv.vb[31:16];
    end
  end

  // output register
  logic [31:0] a_new_q, b_new_q;
  logic        ov_out_q, app_out_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      a_new_q   <= {ay_d, ax_d};
      b_new_q   <= {by_d, bx_d};
      ov_out_q  <= side_dv.ov;
      app_out_q <= side_dv.app;
    end
  end

  assign valid_o           = out_v_q;
  assign a_vel_new_o       = a_new_q;
  assign b_vel_new_o       = b_new_q;
  assign overlap_o         = ov_out_q;
  assign impulse_applied_o = app_out_q;

  // an impulse is only ever applied to an overlapping pair
  a_app_needs_ov : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!impulse_applied_o || overlap_o))
    else $error("impulse applied without overlap");

  // input stalls only when every stage and the output are full
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (out_v_q && stall_i && (v_q == {NST{1'b1}})))
    else $error("input stalled with a free stage");

  // a held first stage keeps its word
  a_first_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !rdy[1]) |=> v_q[0])
    else $error("word lost in first stage");

  // the output word leaves only when taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && stall_i) |=> (out_v_q && $stable(a_new_q) && $stable(b_new_q)))
    else $error("held result changed");

endmodule
